// ===== rtl/assert_macros.svh =====
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FGN_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FGN_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FGN_ASSERT(lbl, clk, rstn, prop, msg)
`define FGN_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/fgn_pkg.sv =====
`timescale 1ns / 1ps
package fgn_pkg;
	localparam int COORD_BITS      = 10;
	localparam int MAX_OCTAVES     = 16;
	localparam int SINE_TABLE_BITS = 10;
	localparam int OCT_BITS        = 4;
	localparam int POS_BITS        = COORD_BITS + 24;
	localparam int QBITS           = SINE_TABLE_BITS - 2;
	localparam int QUARTER         = 1 << QBITS;
	localparam int PIPE_DEPTH      = 20;

	localparam logic [31:0] HASH_A = 32'd3284157443;
	localparam logic [31:0] HASH_B = 32'd1911520717;
	localparam logic [31:0] HASH_C = 32'd2048419325;

	typedef enum logic [1:0] {
		REG_CELL_STEP     = 2'd0,
		REG_OCTAVE_COUNT  = 2'd1,
		REG_CONTRAST_GAIN = 2'd2,
		REG_HEIGHT_SCALE  = 2'd3
	} cfg_reg_t;

	typedef logic [16:0] qsin_tab_t [QUARTER+1];

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	// quarter-wave sine, Q1.16, built at elaboration
	function automatic qsin_tab_t qsin_build();
		qsin_tab_t t;
		longint u, u2, p, s;
		for (int k = 0; k <= QUARTER; k++) begin
			u  = longint'(k) << (16 - QBITS);
			u2 = (u * u) >>> 16;
			p  = -307;
			p  = ((p * u2) >>> 16) + 5223;
			p  = ((p * u2) >>> 16) - 42335;
			p  = ((p * u2) >>> 16) + 102944;
			s  = (p * u) >>> 16;
			if (s < 0) s = 0;
			if (s > 65536) s = 65536;
			t[k] = 17'(s);
		end
		return t;
	endfunction

	localparam qsin_tab_t QSIN = qsin_build();

	function automatic logic signed [17:0] sine_val(input logic [SINE_TABLE_BITS-1:0] idx);
		logic [1:0] q;
		logic [QBITS:0] k;
		logic signed [17:0] s;
		q = idx[SINE_TABLE_BITS-1 -: 2];
		k = q[0] ? (QBITS+1)'(QUARTER) - {1'b0, idx[QBITS-1:0]} : {1'b0, idx[QBITS-1:0]};
		s = $signed({1'b0, QSIN[k]});
		return q[1] ? -s : s;
	endfunction
endpackage

// ===== rtl/fgn_octave.sv =====
`timescale 1ns / 1ps
// One octave of gradient noise, ten register stages.
module fgn_octave (
	input  logic                              clk,
	input  logic [fgn_pkg::POS_BITS-1:0]      pos_x,
	input  logic [fgn_pkg::POS_BITS-1:0]      pos_y,
	input  logic [fgn_pkg::OCT_BITS-1:0]      oct,
	output logic signed [19:0]                value
);
	localparam int TB = fgn_pkg::SINE_TABLE_BITS;

	logic [63:0] shx, shy;
	logic [15:0] fx, fy;
	logic [31:0] ix, iy;
	assign shx = 64'(pos_x) << oct;
	assign shy = 64'(pos_y) << oct;
	assign fx  = shx[23:8];
	assign fy  = shy[23:8];
	assign ix  = shx[55:24];
	assign iy  = shy[55:24];

	// stage 1: first hash multiply, weight square
	logic [31:0] a_s1 [2];
	logic [31:0] j_s1 [2];
	logic [15:0] fx_s1, fy_s1;
	logic [31:0] wwx_s1, wwy_s1;
	always_ff @(posedge clk) begin
		a_s1[0] <= ix * fgn_pkg::HASH_A;
		a_s1[1] <= (ix + 32'd1) * fgn_pkg::HASH_A;
		j_s1[0] <= iy;
		j_s1[1] <= iy + 32'd1;
		fx_s1   <= fx;
		fy_s1   <= fy;
		wwx_s1  <= 32'(fx) * 32'(fx);
		wwy_s1  <= 32'(fy) * 32'(fy);
	end

	// stage 2
	logic [17:0] kx, ky;
	logic [49:0] tx, ty;
	assign kx = 18'd196608 - {1'b0, fx_s1, 1'b0};
	assign ky = 18'd196608 - {1'b0, fy_s1, 1'b0};
	assign tx = 50'(wwx_s1) * 50'(kx);
	assign ty = 50'(wwy_s1) * 50'(ky);

	logic [31:0] b_s2 [4];
	logic [31:0] a_s2 [2];
	logic [15:0] fx_s2, fy_s2;
	logic [16:0] sx_s2, sy_s2;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			b_s2[c] <= (j_s1[c[1]] ^ fgn_pkg::rot16(a_s1[c[0]])) * fgn_pkg::HASH_B;
		end
		a_s2  <= a_s1;
		fx_s2 <= fx_s1;
		fy_s2 <= fy_s1;
		sx_s2 <= tx[48:32];
		sy_s2 <= ty[48:32];
	end

	// stage 3: final hash multiply
	logic [31:0] h_s3 [4];
	logic [15:0] fx_s3, fy_s3;
	logic [16:0] sx_s3, sy_s3;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			h_s3[c] <= (a_s2[c[0]] ^ fgn_pkg::rot16(b_s2[c])) * fgn_pkg::HASH_C;
		end
		fx_s3 <= fx_s2;
		fy_s3 <= fy_s2;
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
	end

	// stage 4: gradient lookup
	logic [TB-1:0] gi [4];
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			gi[c] = h_s3[c][31 -: TB];
		end
	end

	logic signed [17:0] gx_s4 [4];
	logic signed [17:0] gy_s4 [4];
	logic [15:0] fx_s4, fy_s4;
	logic [16:0] sx_s4, sy_s4;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			gx_s4[c] <= fgn_pkg::sine_val(gi[c]);
			gy_s4[c] <= fgn_pkg::sine_val(gi[c] + TB'(fgn_pkg::QUARTER));
		end
		fx_s4 <= fx_s3;
		fy_s4 <= fy_s3;
		sx_s4 <= sx_s3;
		sy_s4 <= sy_s3;
	end

	// stage 5: dot product terms
	logic signed [17:0] dx [2];
	logic signed [17:0] dy [2];
	assign dx[0] = $signed({2'b00, fx_s4});
	assign dx[1] = $signed({2'b00, fx_s4}) - 18'sd65536;
	assign dy[0] = $signed({2'b00, fy_s4});
	assign dy[1] = $signed({2'b00, fy_s4}) - 18'sd65536;

	logic signed [35:0] mx_s5 [4];
	logic signed [35:0] my_s5 [4];
	logic [16:0] sx_s5, sy_s5;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			mx_s5[c] <= dx[c[0]] * gx_s4[c];
			my_s5[c] <= dy[c[1]] * gy_s4[c];
		end
		sx_s5 <= sx_s4;
		sy_s5 <= sy_s4;
	end

	// stage 6
	logic signed [36:0] dsum [4];
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			dsum[c] = 37'(mx_s5[c]) + 37'(my_s5[c]);
		end
	end

	logic signed [19:0] dot_s6 [4];
	logic [16:0] sx_s6, sy_s6;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			dot_s6[c] <= $signed(dsum[c][35:16]);
		end
		sx_s6 <= sx_s5;
		sy_s6 <= sy_s5;
	end

	// stage 7: x blend products
	logic signed [38:0] dtop_s7, dbot_s7;
	logic signed [19:0] d0_s7, d2_s7;
	logic [16:0] sy_s7;
	always_ff @(posedge clk) begin
		dtop_s7 <= (21'(dot_s6[1]) - 21'(dot_s6[0])) * $signed({1'b0, sx_s6});
		dbot_s7 <= (21'(dot_s6[3]) - 21'(dot_s6[2])) * $signed({1'b0, sx_s6});
		d0_s7   <= dot_s6[0];
		d2_s7   <= dot_s6[2];
		sy_s7   <= sy_s6;
	end

	// stage 8
	logic signed [19:0] top_s8, bot_s8;
	logic [16:0] sy_s8;
	always_ff @(posedge clk) begin
		top_s8 <= 20'(39'(d0_s7) + (dtop_s7 >>> 16));
		bot_s8 <= 20'(39'(d2_s7) + (dbot_s7 >>> 16));
		sy_s8  <= sy_s7;
	end

	// stage 9: y blend product
	logic signed [38:0] dv_s9;
	logic signed [19:0] top_s9;
	always_ff @(posedge clk) begin
		dv_s9  <= (21'(bot_s8) - 21'(top_s8)) * $signed({1'b0, sy_s8});
		top_s9 <= top_s8;
	end

	// stage 10
	always_ff @(posedge clk) begin
		value <= 20'(39'(top_s9) + (dv_s9 >>> 16));
	end
endmodule

// ===== rtl/fgn_sum.sv =====
`timescale 1ns / 1ps
// Octave weighting, adder tree, gain, clip and scale: eight stages.
module fgn_sum (
	input  logic                   clk,
	input  logic signed [19:0]     value [fgn_pkg::MAX_OCTAVES],
	input  logic [4:0]             octave_count,
	input  logic [17:0]            contrast_gain,
	input  logic [23:0]            height_scale,
	output logic signed [24:0]     height
);
	localparam int N = fgn_pkg::MAX_OCTAVES;

	logic [4:0] cnt_sat;
	assign cnt_sat = (octave_count > 5'(N)) ? 5'(N) : octave_count;

	logic signed [39:0] term_s1 [16];
	logic signed [39:0] l1_s2 [8];
	logic signed [39:0] l2_s3 [4];
	logic signed [39:0] l3_s4 [2];
	logic signed [39:0] sum_s5;
	logic signed [58:0] prod_s6;
	logic signed [42:0] prod_s7;
	logic signed [26:0] gained;
	logic signed [17:0] clipped;

	always_ff @(posedge clk) begin
		for (int o = 0; o < 16; o++) begin
			if (o < N && 5'(o) < cnt_sat) begin
				term_s1[o] <= 40'(value[o % N]) <<< (16 - o);
			end else begin
				term_s1[o] <= '0;
			end
		end
		for (int k = 0; k < 8; k++) l1_s2[k] <= term_s1[2*k] + term_s1[2*k+1];
		for (int k = 0; k < 4; k++) l2_s3[k] <= l1_s2[2*k] + l1_s2[2*k+1];
		for (int k = 0; k < 2; k++) l3_s4[k] <= l2_s3[2*k] + l2_s3[2*k+1];
		sum_s5  <= l3_s4[0] + l3_s4[1];
		prod_s6 <= 59'(sum_s5) * 59'($signed({1'b0, contrast_gain}));
		prod_s7 <= 43'(clipped) * 43'($signed({1'b0, height_scale}));
		height  <= $signed(prod_s7[40:16]);
	end

	// clip gained sum to +-1.0
	assign gained = $signed(prod_s6[58:32]);
	always_comb begin
		if (gained > 27'sd65536) begin
			clipped = 18'sd65536;
		end else if (gained < -27'sd65536) begin
			clipped = -18'sd65536;
		end else begin
			clipped = 18'(gained);
		end
	end
endmodule

// ===== rtl/fractal_gradient_noise_top.sv =====
// Output: height and strobe are both registered, at the last stage of the data
//   path and of the valid chain, and the receiver takes the transaction while strobe is high.
// Throughput: one transaction per cycle; busy is never raised and every
//   octave lane is its own pipeline, so the rate is set by no shared unit.
// Reset: arst_n clears the valid chain and loads register defaults;
//   in-flight transactions are dropped. The receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fractal_gradient_noise_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [fgn_pkg::COORD_BITS-1:0]   pixel_x,
	input  logic [fgn_pkg::COORD_BITS-1:0]   pixel_y,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [23:0]                      cfg_data,
	output logic signed [24:0]               height,
	output logic                             strobe
);
	localparam int N = fgn_pkg::MAX_OCTAVES;

	// configuration registers
	logic [23:0] cell_step_q;
	logic [4:0]  octave_count_q;
	logic [17:0] contrast_gain_q;
	logic [23:0] height_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_step_q     <= 24'd41943;
			octave_count_q  <= 5'd12;
			contrast_gain_q <= 18'd78643;
			height_scale_q  <= 24'd1310720;
		end else if (cfg_we) begin
			case (fgn_pkg::cfg_reg_t'(cfg_index))
				fgn_pkg::REG_CELL_STEP:     cell_step_q     <= cfg_data;
				fgn_pkg::REG_OCTAVE_COUNT:  octave_count_q  <= cfg_data[4:0];
				fgn_pkg::REG_CONTRAST_GAIN: contrast_gain_q <= cfg_data[17:0];
				fgn_pkg::REG_HEIGHT_SCALE:  height_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// fully pipelined, never back-pressures
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// valid chain runs alongside the data path
	logic [fgn_pkg::PIPE_DEPTH-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[fgn_pkg::PIPE_DEPTH-2:0], accept};
		end
	end
	assign strobe = vld_q[fgn_pkg::PIPE_DEPTH-1];

	// stage 1: capture coordinates
	logic [fgn_pkg::COORD_BITS-1:0] px_s1, py_s1;
	always_ff @(posedge clk) begin
		px_s1 <= pixel_x;
		py_s1 <= pixel_y;
	end

	// stage 2: lattice position = pixel * cell_step (Q.24)
	logic [fgn_pkg::POS_BITS-1:0] pos_x_s2, pos_y_s2;
	always_ff @(posedge clk) begin
		pos_x_s2 <= fgn_pkg::POS_BITS'(px_s1) * fgn_pkg::POS_BITS'(cell_step_q);
		pos_y_s2 <= fgn_pkg::POS_BITS'(py_s1) * fgn_pkg::POS_BITS'(cell_step_q);
	end

	// stages 3-12: one lane per octave, octave o at position << o
	logic signed [19:0] oct_val [N];
	for (genvar g = 0; g < N; g++) begin : g_lane
		fgn_octave u_oct (
			.clk   (clk),
			.pos_x (pos_x_s2),
			.pos_y (pos_y_s2),
			.oct   (fgn_pkg::OCT_BITS'(g)),
			.value (oct_val[g])
		);
	end

	// stages 13-20: weighted sum, gain, clip, scale
	fgn_sum u_sum (
		.clk           (clk),
		.value         (oct_val),
		.octave_count  (octave_count_q),
		.contrast_gain (contrast_gain_q),
		.height_scale  (height_scale_q),
		.height        (height)
	);

	`FGN_ASSERT(a_strobe_follows_start, clk, arst_n, strobe |-> $past(accept, 20), "strobe without start")
	`FGN_ASSERT(a_height_range, clk, arst_n, strobe |-> (height != -25'sd16777216), "height out of range")
	`FGN_ASSERT_NR(a_never_busy, clk, !busy, "busy raised")
endmodule

// ===== verif/fractal_gradient_noise_top_tb.sv =====
`timescale 1ns / 1ps
module fractal_gradient_noise_top_tb;
	import fgn_pkg::*;

	localparam int LAT_WAIT    = PIPE_DEPTH + 6;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
	} pixel_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [COORD_BITS-1:0]   pixel_x;
	logic [COORD_BITS-1:0]   pixel_y;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [23:0]             cfg_data;
	logic signed [24:0]      height;
	logic                    strobe;

	fractal_gradient_noise_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.height    (height),
		.strobe    (strobe)
	);

	// predictor's copy of the register file
	logic [23:0] step_q16  = 24'd41943;
	logic [4:0]  oct_num   = 5'd12;
	logic [17:0] gain_q16  = 18'd78643;
	logic [23:0] scale_q16 = 24'd1310720;

	pixel_t               pixels_pending[$];
	logic signed [24:0]   heights_due[$];
	int                   mismatches = 0;
	int                   bad_count  = 0;
	int                   gap        = 0;
	int                   cycles     = 0;
	bit                   calm       = 0;  // no sender idling in the tail of the run

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic logic [31:0] lattice_hash(input logic [31:0] i, input logic [31:0] j);
		logic [31:0] a, b;
		a = i * HASH_A;
		b = j ^ {a[15:0], a[31:16]};
		b = b * HASH_B;
		a = a ^ {b[15:0], b[31:16]};
		return a * HASH_C;
	endfunction

	// full-turn sine table entry, Q1.16, mirrored from the first quadrant
	function automatic longint wave(input logic [SINE_TABLE_BITS-1:0] idx);
		logic [1:0] quad;
		longint u, u2, p, s;
		quad = idx[SINE_TABLE_BITS-1 -: 2];
		u = longint'(idx[QBITS-1:0]) << (16 - QBITS);
		if (quad[0]) u = 65536 - u;
		u2 = (u * u) >>> 16;
		p = -307;
		p = ((p * u2) >>> 16) + 5223;
		p = ((p * u2) >>> 16) - 42335;
		p = ((p * u2) >>> 16) + 102944;
		s = (p * u) >>> 16;
		if (s < 0) s = 0;
		if (s > 65536) s = 65536;
		return quad[1] ? -s : s;
	endfunction

	function automatic longint grad_dot(input logic [31:0] i, input logic [31:0] j,
			input longint dx, input longint dy);
		logic [31:0] h;
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [SINE_TABLE_BITS-1:0] idx_cos;
		h = lattice_hash(i, j);
		idx = h[31 -: SINE_TABLE_BITS];
		idx_cos = idx + SINE_TABLE_BITS'(QUARTER);
		return (dx * wave(idx) + dy * wave(idx_cos)) >>> 16;
	endfunction

	function automatic longint ease(input longint w);
		return (w * w * (196608 - 2 * w)) >>> 32;
	endfunction

	function automatic longint mix(input longint a0, input longint a1, input longint s);
		return a0 + (((a1 - a0) * s) >>> 16);
	endfunction

	function automatic longint octave_value(input pixel_t p, input int o);
		logic [63:0] xs, ys;
		logic [31:0] ix, iy;
		longint fx, fy, sx, top, bot;
		xs = (64'(p.px) * 64'(step_q16)) << o;
		ys = (64'(p.py) * 64'(step_q16)) << o;
		fx = longint'(xs[23:8]);
		fy = longint'(ys[23:8]);
		ix = xs[55:24];
		iy = ys[55:24];
		sx = ease(fx);
		top = mix(grad_dot(ix, iy, fx, fy), grad_dot(ix + 1, iy, fx - 65536, fy), sx);
		bot = mix(grad_dot(ix, iy + 1, fx, fy - 65536),
			grad_dot(ix + 1, iy + 1, fx - 65536, fy - 65536), sx);
		return mix(top, bot, ease(fy));
	endfunction

	function automatic logic signed [24:0] terrain_height(input pixel_t p);
		int n;
		longint sum, v, h;
		n = (oct_num > MAX_OCTAVES) ? MAX_OCTAVES : int'(oct_num);
		sum = 0;
		for (int o = 0; o < n; o++)
			sum += octave_value(p, o) * (longint'(1) << (16 - o));
		v = (sum * longint'(gain_q16)) >>> 32;
		if (v > 65536) v = 65536;
		if (v < -65536) v = -65536;
		h = (v * longint'(scale_q16)) >>> 16;
		return h[24:0];
	endfunction

	// ---------------- driver ----------------
	// Prediction is made on the accepting edge; registers only change while idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			pixel_x <= '0;
			pixel_y <= '0;
		end else begin
			pixel_t nxt;
			if (start && !busy)
				heights_due = {heights_due, terrain_height('{px: pixel_x, py: pixel_y})};
			if (start && busy) begin
				// hold the transaction until taken
			end else if (gap > 0) begin
				gap   <= gap - 1;
				start <= 1'b0;
			end else if (pixels_pending.size() > 0) begin
				if (!calm && $urandom_range(0, 15) == 0) begin
					gap   <= $urandom_range(0, 17);
					start <= 1'b0;
				end else begin
					nxt = pixels_pending.pop_front();
					pixel_x <= nxt.px;
					pixel_y <= nxt.py;
					start   <= 1'b1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	// Results cannot be held off: a strobe is one transaction, checked at its closing edge.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (heights_due.size() == 0) begin
				bad_count++;
				if (mismatches++ < 10)
					$display("unexpected height %0d", height);
			end else begin
				logic signed [24:0] want;
				want = heights_due.pop_front();
				if (height !== want) begin
					bad_count++;
					if (mismatches++ < 10)
						$display("height mismatch: expected %0d actual %0d", want, height);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[fractal_gradient_noise_top] ERROR");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	task automatic reg_write(input cfg_reg_t idx, input logic [23:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			REG_CELL_STEP:     step_q16  = v;
			REG_OCTAVE_COUNT:  oct_num   = v[4:0];
			REG_CONTRAST_GAIN: gain_q16  = v[17:0];
			REG_HEIGHT_SCALE:  scale_q16 = v;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_regs(input logic [23:0] st, input logic [4:0] oc,
			input logic [17:0] gn, input logic [23:0] sc);
		reg_write(REG_CELL_STEP, st);
		reg_write(REG_OCTAVE_COUNT, 24'(oc));
		reg_write(REG_CONTRAST_GAIN, 24'(gn));
		reg_write(REG_HEIGHT_SCALE, sc);
	endtask

	// waits for the sender to run dry and every height to come back
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pixels_pending.size() != 0 || start || heights_due.size() != 0);
		repeat (LAT_WAIT) @(posedge clk);
	endtask

	task automatic push_px(input int x, input int y);
		pixel_t item;
		item.px = COORD_BITS'(x);
		item.py = COORD_BITS'(y);
		pixels_pending = {pixels_pending, item};
	endtask

	task automatic push_corners();
		push_px(0, 0);
		push_px(1023, 1023);
		push_px(1023, 0);
		push_px(0, 1023);
	endtask

	task automatic push_random(input int n);
		for (int k = 0; k < n; k++)
			push_px($urandom_range(0, 1023), $urandom_range(0, 1023));
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset defaults, field extremes and alternating bit patterns
		push_corners();
		push_px(682, 341);
		push_px(341, 682);
		push_px(1, 1);
		push_px(512, 512);
		drain();

		// cell step, gain and scale at their top values, octave count at MAX_OCTAVES
		load_regs(24'hFFFFFF, 5'd16, 18'h3FFFF, 24'hFFFFFF);
		push_corners();
		push_px(333, 777);
		drain();

		// zero cell step: height stays zero
		load_regs(24'd0, 5'd12, 18'd78643, 24'd1310720);
		push_px(1023, 517);
		push_px(5, 900);
		drain();

		// zero octaves, then octave count beyond the table (saturates)
		load_regs(24'd41943, 5'd0, 18'd200000, 24'hFFFFFF);
		push_px(1023, 1023);
		push_px(100, 200);
		drain();
		load_regs(24'd1, 5'd31, 18'd0, 24'd0);
		push_px(1023, 1023);
		push_px(17, 900);
		drain();
		reg_write(REG_CONTRAST_GAIN, 24'd262143);
		reg_write(REG_HEIGHT_SCALE, 24'd65536);
		push_corners();
		drain();

		// random part: register settings change between phases
		for (int ph = 0; ph < 10; ph++) begin
			load_regs(
				(ph % 3 == 0) ? 24'($urandom_range(1, 200000)) : 24'($urandom),
				5'($urandom_range(0, 31)),
				18'($urandom),
				24'($urandom));
			if (ph == 9) calm = 1;
			push_random(170);
			drain();
		end

		if (bad_count == 0 && heights_due.size() == 0) begin
			$display("[fractal_gradient_noise_top] OK");
		end else begin
			$display("[fractal_gradient_noise_top] ERROR");
		end
		$finish;
	end
endmodule
